// File: rtl/urb_pkg.sv
package urb_pkg;

    // Default depth of the receive FIFO, in bytes.
    localparam int RX_DEPTH_DEF = 16;

    // Width of a bus word.
    localparam int WORD_W = 32;
    localparam int BYTE_W = 8;
    localparam int OFS_W  = 8;
    localparam int CMD_W  = 2;

    // Register offsets within the bus window.
    localparam logic [OFS_W-1:0] OFS_CTRL = 8'h00;
    localparam logic [OFS_W-1:0] OFS_DATA = 8'h04;

    // Bit positions in the control register.
    localparam int CTRL_INT_EN_BIT = 0;
    localparam int CTRL_READY_BIT  = 1;

    // Item commands. Code 3 is unused and is handled by default arms.
    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PUSH  = 2'd2
    } cmd_t;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } state_t;

    // One result word.
    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              irq_strobe;
        logic              rx_overflow;
    } result_t;

endpackage

// File: rtl/urb_if.sv
// Request channel: one bus access or one received byte per word.
interface urb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] reg_offset;
    logic [31:0] write_value;
    logic [7:0] rx_byte;

    modport source (
        output valid, command, reg_offset, write_value, rx_byte,
        input  ready
    );
    modport sink (
        input  valid, command, reg_offset, write_value, rx_byte,
        output ready
    );
endinterface

// Response channel: exactly one word per request.
interface urb_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_strobe;
    logic        rx_overflow;

    modport source (
        output valid, read_value, tx_valid, tx_byte, irq_strobe, rx_overflow,
        input  ready
    );
    modport sink (
        input  valid, read_value, tx_valid, tx_byte, irq_strobe, rx_overflow,
        output ready
    );
endinterface

// File: rtl/uart_register_block_with_rx_fifo.sv
// UART register block with a receive FIFO. Each request word is a bus read,
// a bus write or a byte received from the serial line, and each one yields
// exactly one response word, in order. Offset 0 is the control register: bit 0
// is the interrupt enable, and bit 1 reads as data ready while the receive
// FIFO holds a byte. Offset 4 is the data register: a read pops the oldest
// received byte, zero-extended, or returns 0 when the FIFO is empty, and a
// write hands the low byte out as a transmit byte. Other offsets read 0 and
// ignore writes. A received byte is pushed into the FIFO of RX_DEPTH bytes;
// when the FIFO is full the byte is dropped and rx_overflow is set. In both
// cases irq_strobe follows the interrupt enable. Most requests are answered
// from idle; a data read that pops a byte also passes through the pop state,
// as the synchronous store returns read data in the cycle after the address.
// A finished response sits in an output register, and a new request is
// taken in the same cycle that the waiting response is taken. The store
// needs no clearing after reset: only bytes that were pushed are ever read.

module uart_register_block_with_rx_fifo #(
    parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    urb_req_if.sink  req,
    urb_rsp_if.source rsp
);

    // Pointer width into the store and width of the fill count, which must
    // also hold the full depth.
    localparam int AW = $clog2(RX_DEPTH);
    localparam int CW = $clog2(RX_DEPTH + 1);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic [7:0]    mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    logic [7:0]    mem_rd_data;

    // Sequencer: decodes requests, keeps the enable bit, the FIFO pointers
    // and the fill count, and holds the response register.
    urb_ctrl #(
        .RX_DEPTH (RX_DEPTH),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Receive byte store, written at the tail and read at the head.
    urb_rx_mem #(
        .DEPTH (RX_DEPTH),
        .AW    (AW)
    ) u_rx_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// File: rtl/urb_rx_mem.sv
module urb_rx_mem #(
    parameter int DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] store [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= store[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/urb_ctrl.sv
module urb_ctrl #(
    parameter int RX_DEPTH = urb_pkg::RX_DEPTH_DEF,
    parameter int AW       = $clog2(RX_DEPTH),
    parameter int CW       = $clog2(RX_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    urb_req_if.sink       req,
    urb_rsp_if.source     rsp,
    output logic          mem_wr_en,
    output logic [AW-1:0] mem_wr_addr,
    output logic [7:0]    mem_wr_data,
    output logic          mem_rd_en,
    output logic [AW-1:0] mem_rd_addr,
    input  logic [7:0]    mem_rd_data
);

    import urb_pkg::*;

    state_t        state_reg, state_next;
    logic          irq_en_reg, irq_en_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_data_reg, out_data_next;

    logic          out_free;
    logic          not_empty;
    logic          not_full;
    result_t       res;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CW'(RX_DEPTH));
    assign out_free  = !out_valid_reg || rsp.ready;

    assign mem_wr_addr = tail_reg;
    assign mem_wr_data = req.rx_byte;
    assign mem_rd_addr = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            irq_en_reg    <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            irq_en_reg    <= irq_en_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        irq_en_next    = irq_en_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_wr_en      = 1'b0;
        mem_rd_en      = 1'b0;
        req.ready      = 1'b0;
        res            = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                req.ready = out_free;
                if (req.valid && out_free)
                begin
                    case (cmd_t'(req.command))
                        CMD_READ:
                        begin
                            if (req.reg_offset == OFS_CTRL)
                            begin
                                res.read_value[CTRL_INT_EN_BIT] = irq_en_reg;
                                res.read_value[CTRL_READY_BIT]  = not_empty;
                            end
                            else if (req.reg_offset == OFS_DATA && not_empty)
                            begin
                                // The byte comes back from the store next cycle.
                                mem_rd_en  = 1'b1;
                                head_next  = (head_reg == AW'(RX_DEPTH - 1)) ?
                                             '0 : head_reg + 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (req.reg_offset == OFS_CTRL)
                            begin
                                irq_en_next = req.write_value[CTRL_INT_EN_BIT];
                            end
                            else if (req.reg_offset == OFS_DATA)
                            begin
                                res.tx_valid = 1'b1;
                                res.tx_byte  = req.write_value[7:0];
                            end
                        end
                        CMD_PUSH:
                        begin
                            if (not_full)
                            begin
                                mem_wr_en  = 1'b1;
                                tail_next  = (tail_reg == AW'(RX_DEPTH - 1)) ?
                                             '0 : tail_reg + 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res.rx_overflow = 1'b1;
                            end
                            res.irq_strobe = irq_en_reg;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (state_next == ST_IDLE)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = res;
                    end
                end
            end
            ST_POP:
            begin
                // The output slot was freed when the read was accepted.
                res.read_value = {{(WORD_W - BYTE_W){1'b0}}, mem_rd_data};
                out_valid_next = 1'b1;
                out_data_next  = res;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_data_reg.read_value;
    assign rsp.tx_valid    = out_data_reg.tx_valid;
    assign rsp.tx_byte     = out_data_reg.tx_byte;
    assign rsp.irq_strobe  = out_data_reg.irq_strobe;
    assign rsp.rx_overflow = out_data_reg.rx_overflow;

endmodule
